>>> rtl/core/hcx_pkg.sv
// shared types and constants for the 3x3 hill cipher encryptor
`default_nettype none

package hcx_pkg;

   localparam int LETTER_W  = 5;
   localparam int BLOCK_LEN = 3;
   localparam int KEY_W     = LETTER_W * BLOCK_LEN;
   localparam int CSR_IDX_W = 2;
   localparam int COUNT_W   = 2;
   localparam int ROW_W     = 2;
   localparam int PROD_W    = 2 * LETTER_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int QUOT_W    = 7;

   localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd16;
   localparam int ALPHABET = 26;

   // floor(s / 26) == (s * 2521) >> 16 for every sum below 2^12
   localparam int RECIP_MULT  = 2521;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = SUM_W + 12;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW_ZERO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW_TWO  = 2'd2;

   typedef logic [BLOCK_LEN-1:0][KEY_W-1:0] key_matrix_type;

   typedef struct packed {
      logic [BLOCK_LEN-1:0][LETTER_W-1:0] letters;
      logic [COUNT_W-1:0]                 count;
      logic                               closes;
   } block_type;

endpackage

`default_nettype wire

>>> rtl/core/hcx_front.sv
// front end: gathers letters into blocks of three and hands closed blocks on
`default_nettype none

module hcx_front
   import hcx_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [LETTER_W-1:0] req_plain_letter,
   input  wire logic                req_end_of_message,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output block_type                push_block
);

   logic [COUNT_W-1:0]  fill_ff, fill_in;
   logic [LETTER_W-1:0] hold0_ff, hold0_in;
   logic [LETTER_W-1:0] hold1_ff, hold1_in;
   logic                accept;
   logic                closing;

   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign closing    = (fill_ff == COUNT_W'(BLOCK_LEN - 1)) || req_end_of_message;
   assign push_valid = req_valid && closing;

   always_comb begin
      push_block.letters[0] = (fill_ff == '0) ? req_plain_letter : hold0_ff;
      push_block.letters[1] = (fill_ff == COUNT_W'(1)) ? req_plain_letter :
                              (fill_ff == COUNT_W'(2)) ? hold1_ff : PAD_LETTER;
      push_block.letters[2] = (fill_ff == COUNT_W'(2)) ? req_plain_letter : PAD_LETTER;
      push_block.count      = fill_ff + COUNT_W'(1);
      push_block.closes     = req_end_of_message;
   end

   always_comb begin
      fill_in  = fill_ff;
      hold0_in = hold0_ff;
      hold1_in = hold1_ff;
      if (accept) begin
         if (closing) begin
            fill_in = '0;
         end else begin
            fill_in = fill_ff + COUNT_W'(1);
            if (fill_ff == '0) begin
               hold0_in = req_plain_letter;
            end else begin
               hold1_in = req_plain_letter;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      hold0_ff <= hold0_in;
      hold1_ff <= hold1_in;
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != COUNT_W'(BLOCK_LEN))
      else $error("fill count reached block length");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      accept && closing |=> fill_ff == '0)
      else $error("fill count not cleared after a closed block");

   a_open_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !closing |=> fill_ff == $past(fill_ff) + COUNT_W'(1))
      else $error("fill count did not advance");

endmodule

`default_nettype wire

>>> rtl/core/hcx_queue.sv
// short block queue between the front end and the matrix back end
`default_nettype none

module hcx_queue
   import hcx_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire block_type push_block,
   output logic           pop_valid,
   input  wire logic      pop_ready,
   output block_type      pop_block
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   block_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_block  = mem_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= push_block;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/hcx_back.sv
// back end: one key row per cycle while the result is not stalled, multiply, sum and reduce mod 26
`default_nettype none

module hcx_back
   import hcx_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire key_matrix_type       key_rows,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire block_type            pop_block,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [LETTER_W-1:0]       rsp_cipher_letter,
   output logic                      rsp_last_of_run
);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic              advance;
   logic              final_row;
   logic [KEY_W-1:0]  key_sel;

   // stage one: products
   logic                             p_valid_ff;
   logic                             p_last_ff;
   logic [BLOCK_LEN-1:0][PROD_W-1:0] prod_ff, prod_in;

   // stage two: sum and quotient estimate
   logic               s_valid_ff;
   logic               s_last_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [RECIP_W-1:0] recip_prod;

   // stage three: output register
   logic                rsp_valid_ff;
   logic                rsp_last_ff;
   logic [LETTER_W-1:0] rsp_letter_ff, rsp_letter_in;
   logic [SUM_W-1:0]    remainder;

   // whole pipe moves together, held only by a stalled result beat
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign final_row = (row_ff == ROW_W'(pop_block.count - COUNT_W'(1)));
   assign pop_ready = advance && final_row;

   always_comb begin
      case (row_ff)
         2'd0:    key_sel = key_rows[0];
         2'd1:    key_sel = key_rows[1];
         2'd2:    key_sel = key_rows[2];
         default: key_sel = '0;
      endcase
   end

   always_comb begin
      for (int k = 0; k < BLOCK_LEN; k++) begin
         prod_in[k] = PROD_W'(key_sel[k*LETTER_W +: LETTER_W]) *
                      PROD_W'(pop_block.letters[k]);
      end
   end

   always_comb begin
      row_in = row_ff;
      if (pop_valid && advance) begin
         row_in = final_row ? '0 : row_ff + ROW_W'(1);
      end
   end

   assign sum_in     = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
   assign recip_prod = RECIP_W'(sum_in) * RECIP_W'(RECIP_MULT);
   assign quot_in    = recip_prod[RECIP_SHIFT +: QUOT_W];

   assign remainder     = sum_ff - SUM_W'(quot_ff) * SUM_W'(ALPHABET);
   assign rsp_letter_in = remainder[LETTER_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         p_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         if (advance) begin
            p_valid_ff   <= pop_valid;
            s_valid_ff   <= p_valid_ff;
            rsp_valid_ff <= s_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff       <= prod_in;
         p_last_ff     <= pop_block.closes && final_row;
         sum_ff        <= sum_in;
         quot_ff       <= quot_in;
         s_last_ff     <= p_last_ff;
         rsp_letter_ff <= rsp_letter_in;
         rsp_last_ff   <= s_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cipher_letter = rsp_letter_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_letter_ff < LETTER_W'(ALPHABET))
      else $error("cipher letter out of alphabet");

   a_row_in_block: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> row_ff < ROW_W'(pop_block.count))
      else $error("row index beyond block length");

   a_quot_exact: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff |-> remainder < SUM_W'(ALPHABET))
      else $error("quotient estimate off");

endmodule

`default_nettype wire

>>> rtl/core/hill_cipher_encrypt_3x3.sv
// top level of the 3x3 hill cipher encryptor: key registers and block wiring
// path: a closed block goes through the queue and the product, sum and output
// registers, its rows one per cycle; a stalled result holds rows and letters
// throughput: one plaintext letter per cycle, set by the back end issuing one
// key row per cycle; the queue absorbs blocks closed on consecutive letters
// reset: clears key rows to zero, the fill count, the queue and all valid bits
`default_nettype none

module hill_cipher_encrypt_3x3
   import hcx_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [LETTER_W-1:0]  req_plain_letter,
   input  wire logic                 req_end_of_message,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [LETTER_W-1:0]       rsp_cipher_letter,
   output logic                      rsp_last_of_run,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [KEY_W-1:0]     csr_data
);

   key_matrix_type key_ff, key_in;
   logic           push_valid;
   logic           push_ready;
   block_type      push_block;
   logic           pop_valid;
   logic           pop_ready;
   block_type      pop_block;

   assign csr_ready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_ROW_ZERO: key_in[0] = csr_data;
            CSR_KEY_ROW_ONE:  key_in[1] = csr_data;
            CSR_KEY_ROW_TWO:  key_in[2] = csr_data;
            default:          key_in    = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   hcx_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_plain_letter   (req_plain_letter),
      .req_end_of_message (req_end_of_message),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_block         (push_block)
   );

   hcx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_block (push_block),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_block  (pop_block)
   );

   hcx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .key_rows          (key_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_block         (pop_block),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cipher_letter (rsp_cipher_letter),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

`default_nettype wire
